[hdl/dde_pkg.sv]
// shared constants for the decimal digit emitter
`timescale 1ns / 1ps
package dde_pkg;

  localparam int unsigned MaxDigitsDef = 10;
  localparam int unsigned NumW         = 32;
  localparam int unsigned CntW         = 4;
  localparam int unsigned ColW         = 8;
  localparam int unsigned RowW         = 8;
  localparam int unsigned CodeW        = 6;
  localparam int unsigned CfgW         = 6;
  localparam int unsigned InDataW      = 56;
  localparam int unsigned OutDataW     = 24;

  localparam logic [CodeW-1:0] CodeSpace   = CodeW'(32);
  localparam logic [CodeW-1:0] CodeZero    = CodeW'(48);
  localparam logic [CfgW-1:0]  GlyphHRst   = CfgW'(16);

endpackage

[hdl/dde_dabble.sv]
// iterative binary to bcd converter, one shift and add-3 pass per cycle
`timescale 1ns / 1ps
module dde_dabble #(
  parameter int unsigned MAX_DIGITS = dde_pkg::MaxDigitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dde_pkg::NumW-1:0]    number_i,
  output logic                        done_o,
  output logic [MAX_DIGITS*4-1:0]     bcd_o
);
  import dde_pkg::*;

  localparam int unsigned BcdW  = MAX_DIGITS * 4;
  localparam int unsigned StepW = $clog2(NumW);
  localparam logic [StepW-1:0] LastStep = StepW'(NumW - 1);

  logic [NumW-1:0]  bin_q;
  logic [BcdW-1:0]  bcd_q;
  logic [BcdW-1:0]  bcd_adj;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      bcd_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == LastStep);
      if (start_i) begin
        bin_q  <= number_i;
        bcd_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        bcd_q  <= {bcd_adj[BcdW-2:0], bin_q[NumW-1]};
        bin_q  <= {bin_q[NumW-2:0], 1'b0};
        step_q <= step_q + StepW'(1);
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

[hdl/decimal_digit_emitter_blanking.sv]
// top level: decimal digit emitter with leading-zero blanking
//
// s_axis carries one item: a 32-bit number, a digit count, a start column
// and a row. for each item the block sends one m_axis item per digit, most
// significant first, as an ascii code with its column and row; tlast marks
// the final digit. counts above MAX_DIGITS saturate, a count of zero sends
// nothing. leading zeros become spaces, the final digit is always shown.
// the cfg channel writes the glyph height; digit spacing is half of it.
// the bcd unit converts the number by shift-and-add-3 passes, then one digit
// goes out per cycle while the receiver is ready.
// s_axis_tready is high only while no item is in work, and goes high again
// once the final digit sits in the output register.
// a stalled receiver holds the output register; emission waits for it.
// reset clears the sequencer and the output valid, the glyph height returns to 16.
`timescale 1ns / 1ps
module decimal_digit_emitter_blanking #(
  parameter int unsigned MAX_DIGITS = dde_pkg::MaxDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // number[31:0], digit_count[35:32], start_column[43:36], row[51:44], zero pad
  input  logic [dde_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // char_code[5:0], column[13:6], row_out[21:14], zero pad
  output logic [dde_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dde_pkg::CfgW-1:0]      cfg_data_i
);
  import dde_pkg::*;

  localparam int unsigned DigIdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e               state_q;
  logic [CfgW-1:0]      glyph_h_q;
  logic [DigIdxW-1:0]   pos_q;
  logic                 shown_q;
  logic [ColW-1:0]      col_q;
  logic [RowW-1:0]      row_q;
  logic                 out_valid_q;
  logic [CodeW-1:0]     out_code_q;
  logic [ColW-1:0]      out_col_q;
  logic [RowW-1:0]      out_row_q;
  logic                 out_last_q;

  logic                 in_fire;
  logic [NumW-1:0]      in_number;
  logic [CntW-1:0]      in_count;
  logic [CntW-1:0]      cnt_sat;
  logic                 conv_done;
  logic [MAX_DIGITS*4-1:0]      conv_bcd;
  logic [MAX_DIGITS-1:0][3:0]   digits;
  logic [3:0]           digit;
  logic                 blank;
  logic [CodeW-1:0]     code_next;
  logic [ColW-1:0]      spacing;
  logic                 out_free;
  logic                 emit;

  assign in_number = s_axis_tdata[NumW-1:0];
  assign in_count  = s_axis_tdata[NumW +: CntW];
  assign cnt_sat   = (in_count > MaxCnt) ? MaxCnt : in_count;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  dde_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .number_i(in_number),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  assign digits    = conv_bcd;
  assign digit     = digits[pos_q];
  assign blank     = !shown_q && (pos_q != '0) && (digit == 4'd0);
  assign code_next = blank ? CodeSpace : (CodeZero + CodeW'(digit));
  assign spacing   = ColW'(glyph_h_q[CfgW-1:1]);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign emit      = (state_q == StEmit) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_h_q <= GlyphHRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      glyph_h_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      shown_q     <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire && (cnt_sat != '0)) begin
            pos_q   <= DigIdxW'(cnt_sat - CntW'(1));
            shown_q <= 1'b0;
            col_q   <= s_axis_tdata[NumW + CntW +: ColW];
            row_q   <= s_axis_tdata[NumW + CntW + ColW +: RowW];
            state_q <= StConv;
          end
        end
        StConv: begin
          if (conv_done) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit) begin
            out_code_q  <= code_next;
            out_col_q   <= col_q;
            out_row_q   <= row_q;
            out_last_q  <= (pos_q == '0);
            shown_q     <= shown_q || !blank;
            col_q       <= col_q + spacing;
            pos_q       <= pos_q - DigIdxW'(1);
            if (pos_q == '0) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OutDataW - CodeW - ColW - RowW)'(0), out_row_q, out_col_q, out_code_q};

  // emitted code is a space or a decimal digit
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_code_q == CodeSpace) ||
                    ((out_code_q >= CodeZero) && (out_code_q <= CodeZero + CodeW'(9))))
    else $error("emitted code out of range");

  // final digit of a run is never blanked
  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_code_q != CodeSpace))
    else $error("final digit blanked");

  // conversion finishes only while the sequencer waits for it or is idle
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> (state_q == StConv) || (state_q == StIdle))
    else $error("conversion done outside of conversion");

  // emitting the final digit returns the sequencer to idle with tlast set
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && out_free && pos_q == '0) |=> (state_q == StIdle && out_last_q))
    else $error("run did not end on its final digit");

endmodule

[bench/tb_decimal_digit_emitter_blanking.sv]
// testbench for the decimal digit emitter: directed table, random items, digit predictor
`timescale 1ns / 1ps
module tb_decimal_digit_emitter_blanking;
  import dde_pkg::*;

  localparam int unsigned Limit    = 500000;
  localparam int unsigned HoldOff  = 64;
  localparam int unsigned PerPhase = 20;
  localparam int unsigned NumDir   = 16;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic [CntW-1:0] count;
    logic [ColW-1:0] start;
    logic [RowW-1:0] row;
  } num_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             last;
  } digit_t;

  typedef struct packed {
    logic [NumW-1:0]  number;
    logic [CntW-1:0]  count;
    logic [ColW-1:0]  start;
    logic [RowW-1:0]  row;
    logic             typed;
    logic [CodeW-1:0] code;
    logic [ColW-1:0]  col;
  } dir_row_t;

  typedef enum int unsigned { RxOpen, RxLight, RxPattern, RxHeavy } rx_mode_e;

  // typed rows carry their single digit; count zero rows expect nothing
  localparam dir_row_t DirTab [NumDir] = '{
    '{32'd0,          4'd1,  8'd0,   8'd0,   1'b1, CodeZero,          8'd0},
    '{32'd9,          4'd1,  8'd255, 8'd255, 1'b1, CodeZero + 6'd9,   8'd255},
    '{32'd5,          4'd1,  8'd128, 8'd1,   1'b1, CodeZero + 6'd5,   8'd128},
    '{32'd0,          4'd0,  8'd17,  8'd3,   1'b1, CodeZero,          8'd0},
    '{32'hFFFF_FFFF,  4'd0,  8'd255, 8'd255, 1'b1, CodeZero,          8'd0},
    '{32'hFFFF_FFFF,  4'd10, 8'd0,   8'd0,   1'b0, CodeZero,          8'd0},
    '{32'hFFFF_FFFF,  4'd15, 8'd255, 8'd255, 1'b0, CodeZero,          8'd0},
    '{32'd0,          4'd10, 8'd3,   8'd7,   1'b0, CodeZero,          8'd0},
    '{32'd1000000000, 4'd10, 8'd10,  8'd20,  1'b0, CodeZero,          8'd0},
    '{32'd1000000000, 4'd9,  8'd10,  8'd20,  1'b0, CodeZero,          8'd0},
    '{32'd12345,      4'd3,  8'd40,  8'd2,   1'b0, CodeZero,          8'd0},
    '{32'd100,        4'd5,  8'd60,  8'd4,   1'b0, CodeZero,          8'd0},
    '{32'd7,          4'd11, 8'd250, 8'hA5,  1'b0, CodeZero,          8'd0},
    '{32'h0F0F_0F0F,  4'd12, 8'hAA,  8'h55,  1'b0, CodeZero,          8'd0},
    '{32'hF0F0_F0F0,  4'd13, 8'h55,  8'hAA,  1'b0, CodeZero,          8'd0},
    '{32'd4294967295, 4'd14, 8'd200, 8'd128, 1'b0, CodeZero,          8'd0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  digit_t          digit_q [$];
  logic [CfgW-1:0] glyph_h_q   = GlyphHRst;
  int unsigned     errors      = 0;
  int unsigned     n_items     = 0;
  int unsigned     n_digits    = 0;
  int unsigned     n_cfg       = 0;
  int unsigned     cycles      = 0;
  int unsigned     burst_left  = 0;
  bit              gaps_on     = 1'b1;

  decimal_digit_emitter_blanking dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout with %0d digits outstanding", digit_q.size());
      $display("decimal_digit_emitter_blanking test failed");
      $finish;
    end
  end

  // receiver stall pattern
  logic [15:0] stall_pat  = 16'b1011_0111_0010_1101;
  int unsigned stall_win  = 0;
  rx_mode_e    stall_mode = RxOpen;

  always @(posedge clk_i) begin
    if (stall_win == 0) begin
      stall_win  <= $urandom_range(20, 200);
      stall_mode <= rx_mode_e'($urandom_range(0, 3));
    end else begin
      stall_win <= stall_win - 1;
    end
    case (stall_mode)
      RxOpen:    m_axis_tready <= 1'b1;
      RxLight:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxPattern: m_axis_tready <= stall_pat[cycles[3:0]];
      default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < 40)
      $display("digit %0d %s: got %0d expected %0d", n_digits, what, got, want);
    errors++;
  endtask

  // expected digits of one number at the current glyph height
  task automatic expand_digits(input num_item_t it);
    int unsigned n;
    int unsigned t;
    logic [NumW-1:0] p;
    logic [3:0] dig;
    logic [ColW-1:0] spacing;
    bit seen;
    digit_t d;
    n = (it.count > MaxDigitsDef) ? MaxDigitsDef : it.count;
    spacing = ColW'(glyph_h_q >> 1);
    seen = 1'b0;
    for (t = 0; t < n; t++) begin
      p = 1;
      repeat (n - t - 1) p = p * 10;
      dig = 4'((it.number / p) % 10);
      d.last = (t == n - 1);
      if (!seen && !d.last && dig == 0) begin
        d.code = CodeSpace;
      end else begin
        seen = 1'b1;
        d.code = CodeZero + CodeW'(dig);
      end
      d.column = it.start + ColW'(t) * spacing;
      d.row = it.row;
      digit_q.push_back(d);
    end
  endtask

  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digit_q.size() == 0) begin
        report_mismatch("unexpected item, code", m_axis_tdata[5:0], 0);
      end else begin
        want = digit_q.pop_front();
        if (m_axis_tdata[5:0] !== want.code)
          report_mismatch("char_code", m_axis_tdata[5:0], want.code);
        if (m_axis_tdata[13:6] !== want.column)
          report_mismatch("column", m_axis_tdata[13:6], want.column);
        if (m_axis_tdata[21:14] !== want.row)
          report_mismatch("row_out", m_axis_tdata[21:14], want.row);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
      n_digits++;
    end
  end

  task automatic wait_drained();
    while (digit_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_number(input num_item_t it, input bit predict);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 50)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.row, it.start, it.count, it.number};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict) expand_digits(it);
    n_items++;
  endtask

  task automatic write_glyph_h(input logic [CfgW-1:0] v);
    wait_drained();
    repeat (HoldOff) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    glyph_h_q = v;
    n_cfg++;
  endtask

  function automatic num_item_t random_number();
    num_item_t it;
    int unsigned r;
    logic [NumW-1:0] p;
    r = $urandom_range(0, 15);
    if (r < 2) it.count = CntW'($urandom_range(11, 15));
    else if (r == 2) it.count = '0;
    else it.count = CntW'($urandom_range(1, 10));
    r = $urandom_range(0, 7);
    p = 1;
    repeat ($urandom_range(0, 9)) p = p * 10;
    if (r < 3) it.number = $urandom();
    else if (r < 5) it.number = $urandom_range(0, 999);
    else if (r == 5) it.number = p * $urandom_range(0, 4);
    else it.number = $urandom() % p;
    it.start = ColW'($urandom());
    it.row   = RowW'($urandom());
    return it;
  endfunction

  initial begin
    num_item_t it;
    digit_t d;
    logic [CfgW-1:0] sizes [8];
    int unsigned ph;
    int unsigned k;
    sizes = '{6'd0, 6'd1, 6'd63, 6'd32, 6'd2, 6'd33, 6'd0, 6'd0};
    sizes[6] = CfgW'($urandom_range(0, 63));
    sizes[7] = CfgW'($urandom_range(0, 63));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset glyph height
    for (k = 0; k < NumDir; k++) begin
      it = '{DirTab[k].number, DirTab[k].count, DirTab[k].start, DirTab[k].row};
      send_number(it, !DirTab[k].typed);
      if (DirTab[k].typed && DirTab[k].count == 1) begin
        d = '{DirTab[k].code, DirTab[k].col, DirTab[k].row, 1'b1};
        digit_q.push_back(d);
      end
    end
    s_axis_tvalid <= 1'b0;

    for (ph = 0; ph < 8; ph++) begin
      write_glyph_h(sizes[ph]);
      gaps_on = (ph != 0) && (ph != 4);
      k = 0;
      while (k < PerPhase) begin
        it = random_number();
        send_number(it, 1'b1);
        if (it.count != 0) k++;
        if (k == 3) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
          k++;
        end
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (HoldOff) @(posedge clk_i);
    $display("sent %0d numbers, checked %0d digits", n_items, n_digits);
    $display("glyph height written %0d times, extremes 0, 1, 32 and 63 included", n_cfg);
    if (errors == 0 && digit_q.size() == 0) begin
      $display("decimal_digit_emitter_blanking test passed");
    end else begin
      $display("decimal_digit_emitter_blanking test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/dde_pkg.sv
hdl/dde_dabble.sv
hdl/decimal_digit_emitter_blanking.sv
bench/tb_decimal_digit_emitter_blanking.sv
